>>> src/wwsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wwsa_pkg
// Shared types and constants for the width wrapped signed ALU.
// ----------------------------------------------------------------------------
package wwsa_pkg;

	// Default datapath width.
	localparam int WORD_BITS_DEF = 64;

	// Bits of every operand and result width field.
	localparam int WIDTH_BITS = 7;

	// Action codes.
	typedef enum logic [3:0] {
		ACT_ADD  = 4'd0,
		ACT_SUB  = 4'd1,
		ACT_MUL  = 4'd2,
		ACT_DIV  = 4'd3,
		ACT_NEG  = 4'd4,
		ACT_ABS  = 4'd5,
		ACT_EQ   = 4'd6,
		ACT_GT   = 4'd7,
		ACT_GTEQ = 4'd8,
		ACT_NOT  = 4'd9,
		ACT_AND  = 4'd10,
		ACT_OR   = 4'd11,
		ACT_SEL  = 4'd12
	} action_t;

	// Control that travels with each item down the pipeline.
	typedef struct packed {
		logic                  valid;
		logic [WIDTH_BITS-1:0] rw;
		logic                  dz;
		logic                  is_div;
		logic                  qneg;
	} ctrl_t;

endpackage
`default_nettype wire

>>> src/width_wrapped_signed_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// width_wrapped_signed_alu
// Signed ALU whose operands each carry a bit width; results wrap to width.
// ----------------------------------------------------------------------------
// A new item is taken on every cycle that start is high; busy never rises.
// Each result appears for one cycle, marked by done, and must be captured then
// since the receiver cannot hold it off. The latency is set by the divider,
// which resolves one quotient bit per pipeline stage; every other operation
// is delayed to stay in order with it.
module width_wrapped_signed_alu #(
	parameter int WORD_BITS = wwsa_pkg::WORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [3:0]                         action,
	input  wire logic signed [63:0]                 a_value,
	input  wire logic [wwsa_pkg::WIDTH_BITS-1:0]    a_width,
	input  wire logic signed [63:0]                 b_value,
	input  wire logic [wwsa_pkg::WIDTH_BITS-1:0]    b_width,
	input  wire logic signed [63:0]                 c_value,
	input  wire logic [wwsa_pkg::WIDTH_BITS-1:0]    c_width,
	output logic                                    done,
	output logic signed [63:0]                      result_value,
	output logic [wwsa_pkg::WIDTH_BITS-1:0]         result_width,
	output logic                                    divide_by_zero
);

	localparam int W    = WORD_BITS;
	localparam int WB   = wwsa_pkg::WIDTH_BITS;
	localparam int LO   = (W + 1) / 2;
	localparam int HI   = W - LO;
	localparam int DLY  = W - 2;
	localparam int LAT  = W + 2;
	localparam int IDXB = $clog2(W);
	localparam logic [WB-1:0] W_MAX = WB'(W);
	localparam logic [WB-1:0] W_ONE = WB'(1);

	// The pipeline never stalls.
	assign busy = 1'b0;

	// Clamp a width field into 1 .. W.
	function automatic logic [WB-1:0] clamp_w(input logic [WB-1:0] w);
		logic [WB-1:0] r;
		if (w == '0) begin
			r = W_ONE;
		end else if (w > W_MAX) begin
			r = W_MAX;
		end else begin
			r = w;
		end
		return r;
	endfunction

	// Wrap a W-bit value to rw bits and sign-extend to 64 bits.
	function automatic logic [63:0] wrap_out(input logic [W-1:0] v, input logic [WB-1:0] rw);
		logic [63:0]     r;
		logic [IDXB-1:0] top;
		logic            sgn;
		logic [WB-1:0]   rwm1;
		rwm1 = rw - W_ONE;
		top  = rwm1[IDXB-1:0];
		sgn  = v[top];
		for (int i = 0; i < 64; i++) begin
			if (i < W && WB'(i) < rw) begin
				r[i] = v[i];
			end else begin
				r[i] = sgn;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input decode: wrap operands, clamp widths, pick result width.
	// ------------------------------------------------------------------
	logic [W-1:0]  a_in, b_in, c_in, mag_a_in, mag_b_in;
	logic [WB-1:0] aw_in, bw_in, cw_in, mw_in;
	wwsa_pkg::ctrl_t ctrl_in;

	assign a_in  = a_value[W-1:0];
	assign b_in  = b_value[W-1:0];
	assign c_in  = c_value[W-1:0];
	assign aw_in = clamp_w(a_width);
	assign bw_in = clamp_w(b_width);
	assign cw_in = clamp_w(c_width);
	assign mw_in = (aw_in > bw_in) ? aw_in : bw_in;
	assign mag_a_in = a_in[W-1] ? (W'(0) - a_in) : a_in;
	assign mag_b_in = b_in[W-1] ? (W'(0) - b_in) : b_in;

	always_comb begin
		ctrl_in.valid  = start;
		ctrl_in.dz     = 1'b0;
		ctrl_in.is_div = 1'b0;
		ctrl_in.qneg   = a_in[W-1] ^ b_in[W-1];
		ctrl_in.rw     = mw_in;
		unique case (action)
			wwsa_pkg::ACT_ADD, wwsa_pkg::ACT_SUB, wwsa_pkg::ACT_MUL,
			wwsa_pkg::ACT_AND, wwsa_pkg::ACT_OR: begin
				ctrl_in.rw = mw_in;
			end
			wwsa_pkg::ACT_DIV: begin
				ctrl_in.is_div = 1'b1;
				ctrl_in.dz     = (b_in == '0);
			end
			wwsa_pkg::ACT_NEG, wwsa_pkg::ACT_ABS, wwsa_pkg::ACT_NOT: begin
				ctrl_in.rw = aw_in;
			end
			wwsa_pkg::ACT_EQ, wwsa_pkg::ACT_GT, wwsa_pkg::ACT_GTEQ: begin
				ctrl_in.rw = W_ONE;
			end
			wwsa_pkg::ACT_SEL: begin
				ctrl_in.rw = (a_in != '0) ? bw_in : cw_in;
			end
			default: begin
				ctrl_in.rw = W_ONE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1 registers.
	// ------------------------------------------------------------------
	wwsa_pkg::ctrl_t ctrl_s1;
	logic [3:0]      act_s1;
	logic [W-1:0]    a_s1, b_s1, c_s1, mag_a_s1, mag_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		act_s1   <= action;
		a_s1     <= a_in;
		b_s1     <= b_in;
		c_s1     <= c_in;
		mag_a_s1 <= mag_a_in;
		mag_b_s1 <= mag_b_in;
	end

	// ------------------------------------------------------------------
	// Stage 2: simple operations and the partial products.
	// ------------------------------------------------------------------
	logic [W-1:0]    simple_r;
	logic            gt_r, eq_r;
	logic [2*LO-1:0] pll;
	logic [W-1:0]    plh, phl;

	assign eq_r = (a_s1 == b_s1);
	assign gt_r = ($signed(a_s1) > $signed(b_s1));

	always_comb begin
		unique case (act_s1)
			wwsa_pkg::ACT_ADD:  simple_r = a_s1 + b_s1;
			wwsa_pkg::ACT_SUB:  simple_r = a_s1 - b_s1;
			wwsa_pkg::ACT_NEG:  simple_r = W'(0) - a_s1;
			wwsa_pkg::ACT_ABS:  simple_r = mag_a_s1;
			wwsa_pkg::ACT_EQ:   simple_r = {W{eq_r}};
			wwsa_pkg::ACT_GT:   simple_r = {W{gt_r}};
			wwsa_pkg::ACT_GTEQ: simple_r = {W{gt_r | eq_r}};
			wwsa_pkg::ACT_NOT:  simple_r = ~a_s1;
			wwsa_pkg::ACT_AND:  simple_r = a_s1 & b_s1;
			wwsa_pkg::ACT_OR:   simple_r = a_s1 | b_s1;
			wwsa_pkg::ACT_SEL:  simple_r = (a_s1 != '0) ? b_s1 : c_s1;
			default:            simple_r = '0;
		endcase
	end

	// Low W bits of the product from three half-width multiplies.
	assign pll = {{LO{1'b0}}, a_s1[LO-1:0]} * {{LO{1'b0}}, b_s1[LO-1:0]};
	assign plh = {{HI{1'b0}}, a_s1[LO-1:0]} * {{LO{1'b0}}, b_s1[W-1:LO]};
	assign phl = {{LO{1'b0}}, a_s1[W-1:LO]} * {{HI{1'b0}}, b_s1[LO-1:0]};

	wwsa_pkg::ctrl_t ctrl_s2;
	logic            is_mul_s2;
	logic [W-1:0]    simple_s2, p0_s2;
	logic [HI-1:0]   p1_s2, p2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		is_mul_s2 <= (act_s1 == wwsa_pkg::ACT_MUL);
		simple_s2 <= simple_r;
		p0_s2     <= pll[W-1:0];
		p1_s2     <= plh[HI-1:0];
		p2_s2     <= phl[HI-1:0];
	end

	// ------------------------------------------------------------------
	// Stage 3: finish the product and pick the non-divide result.
	// ------------------------------------------------------------------
	logic [HI-1:0]   cross_sum;
	logic [W-1:0]    mul_r;
	wwsa_pkg::ctrl_t ctrl_s3;
	logic [W-1:0]    r_s3;

	assign cross_sum = p1_s2 + p2_s2;
	assign mul_r     = p0_s2 + {cross_sum, {LO{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s3 <= is_mul_s2 ? mul_r : simple_s2;
	end

	// ------------------------------------------------------------------
	// Delay line that keeps non-divide results in step with the divider.
	// ------------------------------------------------------------------
	wwsa_pkg::ctrl_t ctrl_d [DLY];
	logic [W-1:0]    r_d    [DLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DLY; j++) begin
				ctrl_d[j] <= '0;
			end
		end else begin
			ctrl_d[0] <= ctrl_s3;
			for (int j = 1; j < DLY; j++) begin
				ctrl_d[j] <= ctrl_d[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		r_d[0] <= r_s3;
		for (int j = 1; j < DLY; j++) begin
			r_d[j] <= r_d[j-1];
		end
	end

	// ------------------------------------------------------------------
	// Restoring divider on magnitudes: one quotient bit per stage.
	// ------------------------------------------------------------------
	logic [W:0]   div_rem_s [W+1];
	logic [W-1:0] div_quo_s [W+1];
	logic [W-1:0] div_den_s [W+1];

	assign div_rem_s[0] = '0;
	assign div_quo_s[0] = mag_a_s1;
	assign div_den_s[0] = mag_b_s1;

	for (genvar k = 0; k < W; k++) begin : g_div
		logic [W:0] trial;
		logic       ge;
		assign trial = {div_rem_s[k][W-1:0], div_quo_s[k][W-1]};
		assign ge    = (trial >= {1'b0, div_den_s[k]});
		always_ff @(posedge clk) begin
			div_rem_s[k+1] <= ge ? (trial - {1'b0, div_den_s[k]}) : trial;
			div_quo_s[k+1] <= {div_quo_s[k][W-2:0], ge};
			div_den_s[k+1] <= div_den_s[k];
		end
	end

	// ------------------------------------------------------------------
	// Output stage: sign the quotient or zero it on divide by zero, wrap to the result width.
	// ------------------------------------------------------------------
	wwsa_pkg::ctrl_t ctrl_e;
	logic [W-1:0]    quo_e, final_r;

	assign ctrl_e = ctrl_d[DLY-1];
	assign quo_e  = div_quo_s[W];

	always_comb begin
		if (!ctrl_e.is_div) begin
			final_r = r_d[DLY-1];
		end else if (ctrl_e.dz) begin
			final_r = '0;
		end else if (ctrl_e.qneg) begin
			final_r = W'(0) - quo_e;
		end else begin
			final_r = quo_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_e.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_value   <= wrap_out(final_r, ctrl_e.rw);
		result_width   <= ctrl_e.rw;
		divide_by_zero <= ctrl_e.dz;
	end

`ifndef ASSERT_OFF
	// Every accepted item comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("item did not complete after the pipeline latency");

	// Reported widths stay within the datapath.
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result_width >= W_ONE && result_width <= W_MAX))
		else $error("result width out of range");

	// A divide by zero always returns a zero value.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> (result_value == '0))
		else $error("divide by zero with nonzero result");

	// A one-bit result is either all zeros or all ones.
	a_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_width == W_ONE) |-> (result_value == '0 || result_value == '1))
		else $error("one-bit result not sign-extended");
`endif

endmodule
`default_nettype wire

>>> tb/width_wrapped_signed_alu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// width_wrapped_signed_alu_test
// Drives directed and random items into the width wrapped signed ALU and
// checks every result, field by field, against a predictor of the ALU.
// ----------------------------------------------------------------------------

// Holds the predicted results and compares each result against the oldest.
class alu_scoreboard;
	typedef struct {
		logic [63:0] value;
		logic [6:0]  width;
		logic        dz;
	} alu_result_t;

	alu_result_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Wraps a value to w bits and sign-extends it.
	static function logic [63:0] wrap_to(logic [63:0] v, int unsigned w);
		logic [63:0] mask;
		if (w >= 64) return v;
		mask = (64'd1 << w) - 64'd1;
		v = v & mask;
		if (v[w-1]) v = v | ~mask;
		return v;
	endfunction

	static function int unsigned clamp_w(logic [6:0] w);
		if (w == 0) return 1;
		if (w > 64) return 64;
		return 32'(w);
	endfunction

	// Predicts the result of one accepted item.
	function void note_item(logic [3:0] act, logic [63:0] a, logic [6:0] aw_in,
			logic [63:0] b, logic [6:0] bw_in, logic [63:0] c, logic [6:0] cw_in);
		int unsigned aw, bw, cw, rw;
		logic [63:0] r, q, ma, mb;
		logic dz;
		alu_result_t e;
		aw = clamp_w(aw_in);
		bw = clamp_w(bw_in);
		cw = clamp_w(cw_in);
		rw = (aw > bw) ? aw : bw;
		r = 0;
		dz = 0;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		case (act)
			wwsa_pkg::ACT_ADD: r = a + b;
			wwsa_pkg::ACT_SUB: r = a - b;
			wwsa_pkg::ACT_MUL: r = a * b;
			wwsa_pkg::ACT_DIV: begin
				if (b == 0) begin
					dz = 1;
				end else begin
					q = ma / mb;
					r = (a[63] ^ b[63]) ? -q : q;
				end
			end
			wwsa_pkg::ACT_NEG: begin r = -a; rw = aw; end
			wwsa_pkg::ACT_ABS: begin r = ma; rw = aw; end
			wwsa_pkg::ACT_EQ: begin r = (a == b) ? '1 : '0; rw = 1; end
			wwsa_pkg::ACT_GT: begin r = ($signed(a) > $signed(b)) ? '1 : '0; rw = 1; end
			wwsa_pkg::ACT_GTEQ: begin r = ($signed(a) >= $signed(b)) ? '1 : '0; rw = 1; end
			wwsa_pkg::ACT_NOT: begin r = ~a; rw = aw; end
			wwsa_pkg::ACT_AND: r = a & b;
			wwsa_pkg::ACT_OR: r = a | b;
			wwsa_pkg::ACT_SEL: begin
				if (a != 0) begin r = b; rw = bw; end
				else begin r = c; rw = cw; end
			end
			default: begin r = 0; rw = 1; end
		endcase
		e.value = wrap_to(r, rw);
		e.width = rw[6:0];
		e.dz = dz;
		pending.push_back(e);
	endfunction

	// Compares one result with the oldest prediction.
	function void check_result(logic [63:0] v, logic [6:0] w, logic dz);
		alu_result_t e;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected result value %h width %0d dz %b", $time, v, w, dz);
			return;
		end
		e = pending.pop_front();
		if (v !== e.value) begin
			errors++;
			$display("%0t: result_value expected %h actual %h", $time, e.value, v);
		end
		if (w !== e.width) begin
			errors++;
			$display("%0t: result_width expected %0d actual %0d", $time, e.width, w);
		end
		if (dz !== e.dz) begin
			errors++;
			$display("%0t: divide_by_zero expected %b actual %b", $time, e.dz, dz);
		end
	endfunction
endclass

module width_wrapped_signed_alu_test;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] action;
	logic signed [63:0] a_value, b_value, c_value;
	logic [wwsa_pkg::WIDTH_BITS-1:0] a_width, b_width, c_width;
	logic done;
	logic signed [63:0] result_value;
	logic [wwsa_pkg::WIDTH_BITS-1:0] result_width;
	logic divide_by_zero;

	alu_scoreboard results = new();

	width_wrapped_signed_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .a_value(a_value), .a_width(a_width),
		.b_value(b_value), .b_width(b_width), .c_value(c_value),
		.c_width(c_width), .done(done), .result_value(result_value),
		.result_width(result_width), .divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Check every strobed result at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) results.check_result(result_value, result_width, divide_by_zero);
	end

	// Draws a 64-bit value, often near the edges of the number line.
	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return {1'b1, 63'd0};
			2: return {1'b0, {63{1'b1}}};
			3: return '1;
			4: return 64'($signed($urandom_range(0, 20)) - 10);
			5: return {{32{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 32'($urandom())};
			default: return {32'($urandom()), 32'($urandom())};
		endcase
	endfunction

	function automatic logic [6:0] rand_width();
		case ($urandom_range(0, 9))
			0: return 7'($urandom_range(0, 127));
			1: return 7'd64;
			2: return 7'd1;
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	// Presents one item, holds it until accepted, then idles for a gap.
	task automatic send_item(logic [3:0] act, logic [63:0] a, logic [6:0] aw,
			logic [63:0] b, logic [6:0] bw, logic [63:0] c, logic [6:0] cw, int gap);
		start <= 1'b1;
		action <= act;
		a_value <= a; a_width <= aw;
		b_value <= b; b_width <= bw;
		c_value <= c; c_width <= cw;
		do @(posedge clk); while (busy);
		results.note_item(act, a, aw, b, bw, c, cw);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(int gap);
		logic [3:0] act;
		logic [63:0] b;
		act = ($urandom_range(0, 20) == 0) ? 4'($urandom_range(13, 15))
			: 4'($urandom_range(0, 12));
		b = rand_value();
		if (act == wwsa_pkg::ACT_DIV && $urandom_range(0, 9) == 0) b = 0;
		send_item(act, rand_value(), rand_width(), b, rand_width(),
			rand_value(), rand_width(), gap);
	endtask

	localparam logic [63:0] MOST_NEG = {1'b1, 63'd0};
	localparam logic [63:0] MOST_POS = {1'b0, {63{1'b1}}};

	initial begin
		int gap;
		int n;
		arst_n = 0;
		start = 0;
		action = 0;
		a_value = 0; b_value = 0; c_value = 0;
		a_width = 1; b_width = 1; c_width = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: every action, width extremes and the special cases.
		for (int i = 0; i <= 12; i++)
			send_item(4'(i), MOST_POS, 7'd64, 64'd3, 7'd8, 64'hA5, 7'd4, 0);
		send_item(wwsa_pkg::ACT_DIV, 64'd77, 7'd16, 64'd0, 7'd40, 0, 7'd1, 0);
		send_item(wwsa_pkg::ACT_DIV, MOST_NEG, 7'd64, '1, 7'd64, 0, 7'd1, 2);
		send_item(wwsa_pkg::ACT_DIV, -64'sd7, 7'd8, 64'd2, 7'd8, 0, 7'd1, 0);
		send_item(wwsa_pkg::ACT_NEG, MOST_NEG, 7'd64, 0, 7'd1, 0, 7'd1, 0);
		send_item(wwsa_pkg::ACT_ABS, MOST_NEG, 7'd64, 0, 7'd1, 0, 7'd1, 0);
		send_item(wwsa_pkg::ACT_ADD, MOST_POS, 7'd0, 64'd1, 7'd0, 0, 7'd0, 1);
		send_item(wwsa_pkg::ACT_MUL, MOST_POS, 7'd127, MOST_POS, 7'd100, 0, 7'd1, 0);
		send_item(wwsa_pkg::ACT_SEL, 64'd0, 7'd1, '1, 7'd3, '1, 7'd127, 0);
		send_item(wwsa_pkg::ACT_SEL, MOST_NEG, 7'd1, '1, 7'd0, 0, 7'd5, 0);
		send_item(4'd13, '1, 7'd64, '1, 7'd64, '1, 7'd64, 0);
		send_item(4'd15, 0, 7'd0, 0, 7'd0, 0, 7'd0, 0);
		send_item(wwsa_pkg::ACT_GTEQ, -64'sd1, 7'd2, -64'sd1, 7'd2, 0, 7'd1, 0);

		// Random items, with bursts that carry no gaps at all.
		n = 0;
		while (n < 800) begin
			int burst;
			int no_gaps;
			burst = $urandom_range(1, 40);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < burst; k++) begin
				gap = no_gaps ? 0 : $urandom_range(0, 19);
				send_random(gap);
				n++;
			end
		end
		start <= 1'b0;

		wait (results.pending.size() == 0);
		repeat (80) @(posedge clk);
		if (results.errors == 0 && results.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
